>>> sv/vtb_pkg.sv
// Shared types and constants for the vertex transform and bounds unit.
// Used by vtb_div and vertex_transform_bounds_unit; depends on nothing else.
package vtb_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 64;
    localparam int PROD_W    = COORD_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int NUM_ROWS  = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [ROW_W-1:0] ROW_ZERO_RESET  = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_ONE_RESET   = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_TWO_RESET   = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_THREE_RESET = 64'h1000_0000_0000_0000;

    localparam logic signed [COORD_W-1:0] ONE_Q16   = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] POS_LIMIT = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] NEG_LIMIT = 32'sh8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } vtb_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FINISH
    } div_state_t;

    typedef struct packed {
        logic done;
        logic fault;
    } div_status_t;

endpackage

>>> sv/vtb_div.sv
// Signed restoring radix-2 divider giving a saturated Q16.16 quotient.
// Depends on vtb_pkg; instantiated by vertex_transform_bounds_unit.
module vtb_div
    import vtb_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [ACC_W-1:0]    num,
    input  logic signed [ACC_W-1:0]    den,
    output logic signed [COORD_W-1:0]  quot,
    output div_status_t                status
);

    div_state_t                 state_reg, state_next;
    logic [ACC_W-1:0]           r_reg, r_next;
    logic [ACC_W-1:0]           d_reg, d_next;
    logic [COORD_W-1:0]         sh_reg, sh_next;
    logic [COORD_W-1:0]         q_reg, q_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;
    logic                       fault_reg, fault_next;
    logic signed [COORD_W-1:0]  quot_reg, quot_next;

    logic [ACC_W-1:0]           num_mag;
    logic [ACC_W-1:0]           den_mag;
    logic [ACC_W-1:0]           r_shift;
    logic                       ge;
    logic [COORD_W-1:0]         q_step;
    logic                       sat;

    always_comb begin
        num_mag = num[ACC_W-1] ? (~num + 1'b1) : num;
        den_mag = den[ACC_W-1] ? (~den + 1'b1) : den;
        r_shift = {r_reg[ACC_W-2:0], sh_reg[COORD_W-1]};
        ge      = (r_shift >= d_reg);
        q_step  = {q_reg[COORD_W-2:0], ge};
        sat     = neg_reg ? (q_step > 32'h8000_0000) : (q_step > 32'h7FFF_FFFF);

        state_next = state_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        fault_next = fault_reg;
        quot_next  = quot_reg;

        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    neg_next   = num[ACC_W-1] ^ den[ACC_W-1];
                    d_next     = den_mag;
                    r_next     = {16'b0, num_mag[ACC_W-1:16]};
                    sh_next    = {num_mag[15:0], 16'b0};
                    q_next     = '0;
                    cnt_next   = '0;
                    fault_next = 1'b0;
                    if (den == '0) begin
                        fault_next = 1'b1;
                        if (num == '0) begin
                            quot_next = '0;
                        end else if (num[ACC_W-1]) begin
                            quot_next = NEG_LIMIT;
                        end else begin
                            quot_next = POS_LIMIT;
                        end
                        state_next = DIV_FINISH;
                    end else if ({16'b0, num_mag[ACC_W-1:16]} >= den_mag) begin
                        fault_next = 1'b1;
                        quot_next  = (num[ACC_W-1] ^ den[ACC_W-1]) ? NEG_LIMIT : POS_LIMIT;
                        state_next = DIV_FINISH;
                    end else begin
                        state_next = DIV_RUN;
                    end
                end
            end
            DIV_RUN: begin
                r_next   = ge ? (r_shift - d_reg) : r_shift;
                q_next   = q_step;
                sh_next  = {sh_reg[COORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    if (sat) begin
                        fault_next = 1'b1;
                        quot_next  = neg_reg ? NEG_LIMIT : POS_LIMIT;
                    end else begin
                        quot_next  = neg_reg ? $signed(~q_step + 1'b1) : $signed(q_step);
                    end
                    state_next = DIV_FINISH;
                end
            end
            DIV_FINISH: begin
                state_next = DIV_IDLE;
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            fault_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fault_reg <= fault_next;
        end
        r_reg    <= r_next;
        d_reg    <= d_next;
        sh_reg   <= sh_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign quot         = quot_reg;
    assign status.done  = (state_reg == DIV_FINISH);
    assign status.fault = fault_reg;

endmodule

>>> sv/vertex_transform_bounds_unit.sv
// Homogeneous 4x4 vertex transform with a running axis-aligned bounding box.
// Depends on vtb_pkg and instantiates vtb_div.
//
// Each beat on the s_ channel carries one vertex in signed Q16.16 and a
// mesh_start flag. The vertex is multiplied by the configured Q4.12 matrix
// with w taken as one, and x, y and z are divided by the resulting w.
// Each beat on the m_ channel carries the transformed vertex, the bounding
// box since the last mesh start, and a flag that is set when w was zero or a
// coordinate saturated.
// The matrix rows are written through cfg_wr_en, cfg_index and cfg_data;
// the user must write them only while the block is idle, as the block does
// not enforce this itself; an index beyond row three is ignored.
// Each vertex passes through the shared multiply-accumulate unit (sixteen
// products, each a multiply state and an add state), then three divides in
// the shared 50-bit restoring divider, which finishes early when w is zero
// or the quotient overflows early, and then a finish state.
// The block accepts one vertex at a time; s_ready is high only when idle.
// A finished result waits in the output register, so the next vertex may be
// accepted while the receiver stalls; it is not finished until then.
// Reset restores the identity matrix and empties the box.
module vertex_transform_bounds_unit
    import vtb_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [ROW_W-1:0]           cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [COORD_W-1:0]  s_vertex_x,
    input  logic signed [COORD_W-1:0]  s_vertex_y,
    input  logic signed [COORD_W-1:0]  s_vertex_z,
    input  logic                       s_mesh_start,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [COORD_W-1:0]  m_out_x,
    output logic signed [COORD_W-1:0]  m_out_y,
    output logic signed [COORD_W-1:0]  m_out_z,
    output logic signed [COORD_W-1:0]  m_box_min_x,
    output logic signed [COORD_W-1:0]  m_box_min_y,
    output logic signed [COORD_W-1:0]  m_box_min_z,
    output logic signed [COORD_W-1:0]  m_box_max_x,
    output logic signed [COORD_W-1:0]  m_box_max_y,
    output logic signed [COORD_W-1:0]  m_box_max_z,
    output logic                       m_range_fault
);

    vtb_state_t                 state_reg, state_next;
    logic [ROW_W-1:0]           matrix_reg [NUM_ROWS];
    logic signed [COORD_W-1:0]  vx_reg, vy_reg, vz_reg;
    logic                       start_reg;
    logic [3:0]                 k_reg;
    logic [1:0]                 axis_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_run_reg;
    logic signed [ACC_W-1:0]    acc_q_reg [NUM_ROWS];
    logic signed [COORD_W-1:0]  res_q_reg [3];
    logic                       fault_reg;
    logic signed [COORD_W-1:0]  low_reg [3];
    logic signed [COORD_W-1:0]  high_reg [3];
    logic signed [COORD_W-1:0]  out_reg [3];
    logic                       out_fault_reg;
    logic                       m_valid_reg;

    logic                       accept;
    logic                       finish;
    logic                       div_start;
    logic [ROW_W-1:0]           row_word;
    logic signed [COEF_W-1:0]   coef;
    logic signed [COORD_W-1:0]  opnd;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [COORD_W-1:0]  low_next [3];
    logic signed [COORD_W-1:0]  high_next [3];
    logic signed [COORD_W-1:0]  div_quot;
    div_status_t                div_status;

    assign accept = s_valid && s_ready;

    always_comb begin
        row_word  = matrix_reg[k_reg[3:2]];
        coef      = row_word[k_reg[1:0]*COEF_W +: COEF_W];
        case (k_reg[1:0])
            2'd0:    opnd = vx_reg;
            2'd1:    opnd = vy_reg;
            2'd2:    opnd = vz_reg;
            default: opnd = ONE_Q16;
        endcase
        prod_next = coef * opnd;
        acc_sum   = acc_run_reg + ACC_W'(prod_reg);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (start_reg) begin
                low_next[i]  = res_q_reg[i];
                high_next[i] = res_q_reg[i];
            end else begin
                low_next[i]  = (res_q_reg[i] < low_reg[i])  ? res_q_reg[i] : low_reg[i];
                high_next[i] = (res_q_reg[i] > high_reg[i]) ? res_q_reg[i] : high_reg[i];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = (k_reg == 4'd15) ? ST_DIV_GO : ST_MUL;
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_status.done) begin
                    state_next = (axis_reg == 2'd2) ? ST_FIN : ST_DIV_GO;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    vtb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_q_reg[0]),
        .den     (acc_q_reg[NUM_ROWS-1]),
        .quot    (div_quot),
        .status  (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            matrix_reg[0] <= ROW_ZERO_RESET;
            matrix_reg[1] <= ROW_ONE_RESET;
            matrix_reg[2] <= ROW_TWO_RESET;
            matrix_reg[3] <= ROW_THREE_RESET;
            m_valid_reg   <= 1'b0;
            k_reg         <= '0;
            axis_reg      <= '0;
            fault_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                low_reg[i]  <= POS_LIMIT;
                high_reg[i] <= NEG_LIMIT;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_ROWS))) begin
                matrix_reg[cfg_index[1:0]] <= cfg_data;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                k_reg     <= '0;
                axis_reg  <= '0;
                fault_reg <= 1'b0;
            end
            if (state_reg == ST_ACC) begin
                k_reg <= k_reg + 4'd1;
            end
            if (state_reg == ST_DIV_WAIT && div_status.done) begin
                axis_reg  <= axis_reg + 2'd1;
                fault_reg <= fault_reg | div_status.fault;
            end
            if (finish) begin
                for (int i = 0; i < 3; i++) begin
                    low_reg[i]  <= low_next[i];
                    high_reg[i] <= high_next[i];
                end
            end
        end
        if (accept) begin
            vx_reg      <= s_vertex_x;
            vy_reg      <= s_vertex_y;
            vz_reg      <= s_vertex_z;
            start_reg   <= s_mesh_start;
            acc_run_reg <= '0;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_ACC) begin
            if (k_reg[1:0] == 2'd3) begin
                acc_run_reg <= '0;
                for (int i = 0; i < NUM_ROWS - 1; i++) begin
                    acc_q_reg[i] <= acc_q_reg[i+1];
                end
                acc_q_reg[NUM_ROWS-1] <= acc_sum;
            end else begin
                acc_run_reg <= acc_sum;
            end
        end
        if (state_reg == ST_DIV_WAIT && div_status.done) begin
            acc_q_reg[0] <= acc_q_reg[1];
            acc_q_reg[1] <= acc_q_reg[2];
            res_q_reg[0] <= res_q_reg[1];
            res_q_reg[1] <= res_q_reg[2];
            res_q_reg[2] <= div_quot;
        end
        if (finish) begin
            for (int i = 0; i < 3; i++) begin
                out_reg[i] <= res_q_reg[i];
            end
            out_fault_reg <= fault_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_x       = out_reg[0];
    assign m_out_y       = out_reg[1];
    assign m_out_z       = out_reg[2];
    assign m_box_min_x   = low_reg[0];
    assign m_box_min_y   = low_reg[1];
    assign m_box_min_z   = low_reg[2];
    assign m_box_max_x   = high_reg[0];
    assign m_box_max_y   = high_reg[1];
    assign m_box_max_z   = high_reg[2];
    assign m_range_fault = out_fault_reg;

    // The box is never empty once a result has been shown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (low_reg[0] <= high_reg[0]) && (low_reg[1] <= high_reg[1])
                    && (low_reg[2] <= high_reg[2]))
        else $error("bounding box inverted while a result is shown");

    // The divider only reports completion while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the divide phase");

    // An accepted vertex always starts at the first product.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_MUL && k_reg == 4'd0 && axis_reg == 2'd0)
        else $error("sequencer did not restart on an accepted beat");

    // A divide by zero w always marks the result as faulty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (div_start && acc_q_reg[NUM_ROWS-1] == '0) |=> ##1 div_status.fault)
        else $error("zero w not flagged");

endmodule
